// File: hdl/rblr_pkg.sv
// Shared constants, transaction types and helpers for the ring buffer linear resampler.
package rblr_pkg;

	localparam int RING_AW    = 10;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int FILL_W     = RING_AW + 1;
	localparam int FRAC_BITS  = 16;
	localparam int STEP_FRAC  = 16;
	localparam int POS_W      = 48;
	localparam int WCNT_W     = 32;
	localparam int SMP_W      = 24;
	localparam int STEP_W     = 24;
	localparam int MARGIN_W   = 11;
	localparam int CMP_W      = POS_W + 2;
	localparam int PROD_W     = SMP_W + 1 + FRAC_BITS + 1;

	localparam int OUT_DEPTH  = 4;
	localparam int OUT_AW     = 2;
	localparam int OUT_CW     = OUT_AW + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_MARGIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYING       = 2'd2;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [STEP_W-1:0]   STEP_RESET   = 24'd65536;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 11'd256;

	typedef struct packed {
		logic                    req_type;
		logic signed [SMP_W-1:0] sample_value;
	} rblr_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    underrun;
		logic                    refill_request;
	} rblr_out_t;

	// read tick in flight alongside the ring read data
	typedef struct packed {
		logic                 valid;
		logic                 underrun;
		logic                 refill;
		logic                 ok0;
		logic                 ok1;
		logic [FRAC_BITS-1:0] frac;
	} rblr_tag_t;

	function automatic logic [POS_W-1:0] scale_step(input logic [STEP_W-1:0] s);
		logic [POS_W-1:0] w;
		w = POS_W'(s);
		if (FRAC_BITS >= STEP_FRAC)
			return w << (FRAC_BITS - STEP_FRAC);
		else
			return w >> (STEP_FRAC - FRAC_BITS);
	endfunction

endpackage

// File: hdl/rblr_ring_mem.sv
// Sample ring memory: one write port, two registered read ports.
module rblr_ring_mem (
	input  logic                              clk,
	input  logic                              we,
	input  logic [rblr_pkg::RING_AW-1:0]      waddr,
	input  logic [rblr_pkg::SMP_W-1:0]        wdata,
	input  logic                              re,
	input  logic [rblr_pkg::RING_AW-1:0]      raddr0,
	input  logic [rblr_pkg::RING_AW-1:0]      raddr1,
	output logic [rblr_pkg::SMP_W-1:0]        rdata0,
	output logic [rblr_pkg::SMP_W-1:0]        rdata1
);

	logic [rblr_pkg::SMP_W-1:0] mem [rblr_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// File: hdl/rblr_interp.sv
// Interpolation datapath: difference times fraction, then round and offset.
module rblr_interp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rblr_pkg::rblr_tag_t         tag_s1,
	input  logic [rblr_pkg::SMP_W-1:0]  rd0,
	input  logic [rblr_pkg::SMP_W-1:0]  rd1,
	output logic                        res_valid,
	output rblr_pkg::rblr_out_t         res,
	output logic                        busy
);

	logic signed [rblr_pkg::SMP_W-1:0]  s0;
	logic signed [rblr_pkg::SMP_W-1:0]  s1;
	logic signed [rblr_pkg::SMP_W:0]    diff;
	logic signed [rblr_pkg::PROD_W-1:0] prod;

	logic                               valid_s2;
	logic                               under_s2;
	logic                               refill_s2;
	logic signed [rblr_pkg::SMP_W-1:0]  s0_s2;
	logic signed [rblr_pkg::PROD_W-1:0] prod_s2;

	logic signed [rblr_pkg::PROD_W-1:0] rnd;
	logic signed [rblr_pkg::PROD_W-1:0] quo;
	logic signed [rblr_pkg::SMP_W:0]    sum;

	// never-written entries read as zero
	assign s0   = tag_s1.ok0 ? $signed(rd0) : '0;
	assign s1   = tag_s1.ok1 ? $signed(rd1) : '0;
	assign diff = (rblr_pkg::SMP_W+1)'(s1) - (rblr_pkg::SMP_W+1)'(s0);
	assign prod = rblr_pkg::PROD_W'(diff) * $signed({1'b0, tag_s1.frac});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= tag_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			under_s2  <= tag_s1.underrun;
			refill_s2 <= tag_s1.refill;
			s0_s2     <= s0;
			prod_s2   <= prod;
		end
	end

	// round to nearest, ties toward plus infinity
	assign rnd = prod_s2 + (rblr_pkg::PROD_W'(1) <<< (rblr_pkg::FRAC_BITS - 1));
	assign quo = rnd >>> rblr_pkg::FRAC_BITS;
	assign sum = (rblr_pkg::SMP_W+1)'(s0_s2) + quo[rblr_pkg::SMP_W:0];

	assign res_valid          = valid_s2;
	assign res.sample_out     = under_s2 ? '0 : sum[rblr_pkg::SMP_W-1:0];
	assign res.underrun       = under_s2;
	assign res.refill_request = refill_s2;
	assign busy               = valid_s2;

endmodule

// File: hdl/rblr_out_fifo.sv
// Result queue between the datapath and the output channel.
module rblr_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  rblr_pkg::rblr_out_t         push_data,
	input  logic                        pop,
	output rblr_pkg::rblr_out_t         head,
	output logic [rblr_pkg::OUT_CW-1:0] count
);

	rblr_pkg::rblr_out_t             entry_q [rblr_pkg::OUT_DEPTH];
	logic [rblr_pkg::OUT_AW-1:0]     wptr_q;
	logic [rblr_pkg::OUT_AW-1:0]     rptr_q;
	logic [rblr_pkg::OUT_CW-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	assign head  = entry_q[rptr_q];
	assign count = count_q;

endmodule

// File: hdl/ring_buffer_linear_resampler.sv
// Top level: ring buffer linear resampler with read pointer control and config registers.
// A read tick's ring data and tag are registered, then stage s2, then the result queue.
// One transaction (write or read tick) per cycle while req_stall is low; the ring has
// one write and two read ports, and the position advance does not wait on read data.
// Writes produce no result. Reset clears counters, position and queues, restores config
// defaults; the ring is not cleared: a fill count makes never-written entries read as zero.
module ring_buffer_linear_resampler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rblr_pkg::rblr_in_t               req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rblr_pkg::rblr_out_t              rsp_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rblr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rblr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [rblr_pkg::STEP_W-1:0]   step_q;
	logic [rblr_pkg::MARGIN_W-1:0] margin_q;
	logic                          playing_q;
	logic [rblr_pkg::POS_W-1:0]    pos_q;
	logic [rblr_pkg::WCNT_W-1:0]   wcnt_q;
	logic [rblr_pkg::FILL_W-1:0]   fill_q;
	rblr_pkg::rblr_tag_t           tag_s1;

	logic                                      accept;
	logic                                      is_wr;
	logic                                      is_rd;
	logic [rblr_pkg::POS_W-rblr_pkg::FRAC_BITS-1:0] ipart;
	logic [rblr_pkg::RING_AW-1:0]              i0;
	logic [rblr_pkg::RING_AW-1:0]              i1;
	logic [rblr_pkg::RING_AW-1:0]              waddr;
	logic                                      avail;
	logic                                      do_read;
	logic [rblr_pkg::POS_W-1:0]                pos_next;
	logic signed [rblr_pkg::CMP_W-1:0]         thresh;
	logic                                      refill;
	logic [rblr_pkg::FILL_W-1:0]               wcnt_inc;
	logic                                      wcnt_low;

	logic [rblr_pkg::SMP_W-1:0]    rd0;
	logic [rblr_pkg::SMP_W-1:0]    rd1;
	logic                          res_valid;
	rblr_pkg::rblr_out_t           res;
	logic                          busy;
	logic [rblr_pkg::OUT_CW-1:0]   fifo_cnt;
	logic [rblr_pkg::OUT_CW:0]     occupancy;

	assign accept = req_valid && !req_stall;
	assign is_wr  = req_data.req_type == rblr_pkg::REQ_WRITE;
	assign is_rd  = accept && !is_wr;

	assign ipart = pos_q[rblr_pkg::POS_W-1:rblr_pkg::FRAC_BITS];
	assign i0    = ipart[rblr_pkg::RING_AW-1:0];
	assign i1    = i0 + 1'b1;
	assign waddr = wcnt_q[rblr_pkg::RING_AW-1:0];
	assign avail = ipart < wcnt_q;

	assign do_read  = playing_q && avail;
	assign pos_next = do_read ? pos_q + rblr_pkg::scale_step(step_q) : pos_q;

	assign thresh = $signed({2'b00, wcnt_q, {rblr_pkg::FRAC_BITS{1'b0}}})
		- $signed(rblr_pkg::CMP_W'(margin_q) << rblr_pkg::FRAC_BITS);
	assign refill = playing_q && ($signed({2'b00, pos_next}) > thresh);

	assign wcnt_low = wcnt_q[rblr_pkg::WCNT_W-1:rblr_pkg::RING_AW] == '0;
	assign wcnt_inc = rblr_pkg::FILL_W'(waddr) + 1'b1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= rblr_pkg::STEP_RESET;
			margin_q  <= rblr_pkg::MARGIN_RESET;
			playing_q <= 1'b0;
			pos_q     <= '0;
			wcnt_q    <= '0;
			fill_q    <= '0;
			tag_s1    <= '0;
		end else begin
			tag_s1.valid    <= is_rd;
			tag_s1.underrun <= !do_read;
			tag_s1.refill   <= refill;
			tag_s1.ok0      <= rblr_pkg::FILL_W'(i0) < fill_q;
			tag_s1.ok1      <= rblr_pkg::FILL_W'(i1) < fill_q;
			tag_s1.frac     <= pos_q[rblr_pkg::FRAC_BITS-1:0];
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rblr_pkg::CFG_STEP_RATIO: begin
						step_q <= cfg_data[rblr_pkg::STEP_W-1:0];
					end
					rblr_pkg::CFG_REFILL_MARGIN: begin
						margin_q <= cfg_data[rblr_pkg::MARGIN_W-1:0];
					end
					rblr_pkg::CFG_PLAYING: begin
						playing_q <= cfg_data[0];
						pos_q     <= '0;
						wcnt_q    <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (is_wr) begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_low && wcnt_inc > fill_q) begin
						fill_q <= wcnt_inc;
					end
				end else begin
					pos_q <= pos_next;
				end
			end
		end
	end

	rblr_ring_mem u_ring (
		.clk    (clk),
		.we     (accept && is_wr),
		.waddr  (waddr),
		.wdata  (req_data.sample_value),
		.re     (is_rd),
		.raddr0 (i0),
		.raddr1 (i1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	rblr_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.rd0       (rd0),
		.rd1       (rd1),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

	rblr_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (rsp_valid && !rsp_stall),
		.head      (rsp_data),
		.count     (fifo_cnt)
	);

	// queued plus in-flight read ticks must leave room for one more
	assign occupancy = (rblr_pkg::OUT_CW+1)'(fifo_cnt)
		+ (rblr_pkg::OUT_CW+1)'(tag_s1.valid)
		+ (rblr_pkg::OUT_CW+1)'(busy);
	assign req_stall = occupancy >= (rblr_pkg::OUT_CW+1)'(rblr_pkg::OUT_DEPTH);
	assign rsp_valid = fifo_cnt != '0;

endmodule

// File: dv/tb_ring_buffer_linear_resampler.sv
// Self-checking testbench for the ring buffer linear resampler: directed and random stimulus.
module tb_ring_buffer_linear_resampler;
	import rblr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [SMP_W-1:0] SMP_MAX = 24'h7FFFFF;
	localparam logic [SMP_W-1:0] SMP_MIN = 24'h800000;
	localparam logic [SMP_W-1:0] SMP_NEG1 = 24'hFFFFFF;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 150;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	rblr_in_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rblr_out_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ring_buffer_linear_resampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// resampler state as predicted
	logic signed [SMP_W-1:0] ring_m [RING_DEPTH];
	logic [POS_W-1:0] rd_pos;
	logic [WCNT_W-1:0] wr_cnt;
	logic [STEP_W-1:0] step_m;
	logic [MARGIN_W-1:0] margin_m;
	logic playing_m;

	rblr_in_t pending_reqs[$];
	rblr_out_t expected_ticks[$];
	int issued = 0;
	int accepted = 0;
	int mismatches = 0;
	bit quiet = 1'b0;
	int hold_asked = 0;
	int hold_seen;
	int send_gap;
	int stall_left;
	int idle_cycles;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void resample(input rblr_in_t item);
		rblr_out_t r;
		logic [RING_AW-1:0] k0, k1;
		longint lim, thr, a, b, p;
		r = '0;
		r.underrun = 1'b1;
		if (item.req_type == REQ_WRITE) begin
			ring_m[wr_cnt[RING_AW-1:0]] = item.sample_value;
			wr_cnt = wr_cnt + 1'b1;
			return;
		end
		if (playing_m) begin
			lim = longint'(wr_cnt) << FRAC_BITS;
			if (longint'(rd_pos) < lim) begin
				k0 = rd_pos[FRAC_BITS +: RING_AW];
				k1 = k0 + 1'b1;
				a = longint'(ring_m[k0]);
				b = longint'(ring_m[k1]);
				p = (b - a) * longint'(rd_pos[FRAC_BITS-1:0]) + (longint'(1) << (FRAC_BITS - 1));
				r.sample_out = SMP_W'(a + (p >>> FRAC_BITS));
				r.underrun = 1'b0;
				rd_pos = rd_pos + (POS_W'(step_m) << (FRAC_BITS - STEP_FRAC));
			end
			thr = lim - (longint'(margin_m) << FRAC_BITS);
			r.refill_request = longint'(rd_pos) > thr;
		end
		expected_ticks.push_back(r);
	endfunction

	// prediction and checking
	always @(posedge clk or negedge arst_n) begin : scoreboard
		rblr_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring_m[i] = '0;
			rd_pos = '0;
			wr_cnt = '0;
			step_m = STEP_RESET;
			margin_m = MARGIN_RESET;
			playing_m = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STEP_RATIO: step_m = cfg_data[STEP_W-1:0];
					CFG_REFILL_MARGIN: margin_m = cfg_data[MARGIN_W-1:0];
					CFG_PLAYING: begin
						playing_m = cfg_data[0];
						rd_pos = '0;
						wr_cnt = '0;
					end
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				resample(req_data);
				accepted++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_ticks.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_data);
					mismatches++;
				end else begin
					want = expected_ticks.pop_front();
					if (rsp_data.sample_out !== want.sample_out) begin
						$display("%0t: sample_out expected %h actual %h", $time,
							want.sample_out, rsp_data.sample_out);
						mismatches++;
					end
					if (rsp_data.underrun !== want.underrun) begin
						$display("%0t: underrun expected %b actual %b", $time,
							want.underrun, rsp_data.underrun);
						mismatches++;
					end
					if (rsp_data.refill_request !== want.refill_request) begin
						$display("%0t: refill_request expected %b actual %b", $time,
							want.refill_request, rsp_data.refill_request);
						mismatches++;
					end
				end
			end
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_gap <= 0;
		end else if (!req_valid || !req_stall) begin
			if (send_gap != 0) begin
				req_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() == 0) begin
				req_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				req_valid <= 1'b0;
				send_gap <= $urandom_range(0, 15);
			end else begin
				req_valid <= 1'b1;
				req_data <= pending_reqs.pop_front();
			end
		end
	end

	// response stall: random bursts plus one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			rsp_stall <= 1'b1;
			stall_left <= LONG_HOLD;
		end else if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic queue_req(input logic kind, input logic [SMP_W-1:0] v);
		rblr_in_t it;
		it.req_type = kind;
		it.sample_value = v;
		pending_reqs.push_back(it);
		issued++;
	endtask

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			3: return SMP_NEG1;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic settle();
		while (accepted != issued || expected_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [STEP_W-1:0] step_val;
		int wr_pct;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not playing: ticks underrun, writes still land
		queue_req(REQ_READ, '0);
		queue_req(REQ_WRITE, SMP_MAX);
		queue_req(REQ_WRITE, SMP_MIN);
		queue_req(REQ_READ, SMP_NEG1);
		settle();

		write_reg(CFG_PLAYING, CFG_DATA_W'(1));
		queue_req(REQ_READ, '0);
		queue_req(REQ_WRITE, SMP_MAX);
		queue_req(REQ_WRITE, SMP_MIN);
		queue_req(REQ_WRITE, '0);
		queue_req(REQ_WRITE, SMP_NEG1);
		queue_req(REQ_WRITE, 24'd1);
		queue_req(REQ_READ, '0);
		queue_req(REQ_READ, '0);
		settle();

		// half step: rounding ties, runs into the write count
		write_reg(CFG_STEP_RATIO, 24'h008000);
		write_reg(CFG_REFILL_MARGIN, '0);
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		repeat (7) queue_req(REQ_READ, '0);
		settle();

		write_reg(CFG_STEP_RATIO, '0);
		write_reg(CFG_REFILL_MARGIN, CFG_DATA_W'(1024));
		queue_req(REQ_WRITE, rand_sample());
		queue_req(REQ_READ, '0);
		queue_req(REQ_READ, '0);
		settle();

		write_reg(CFG_STEP_RATIO, 24'hFFFFFF);
		queue_req(REQ_READ, '0);
		queue_req(REQ_READ, '0);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 5))
				0: step_val = '0;
				1: step_val = 24'hFFFFFF;
				2: step_val = STEP_RESET;
				3: step_val = STEP_W'($urandom_range(1, 24'h020000));
				4: step_val = STEP_W'($urandom_range(24'h000100, 24'h010000));
				default: step_val = STEP_W'($urandom);
			endcase
			write_reg(CFG_PLAYING, CFG_DATA_W'($urandom_range(0, 5) != 0));
			write_reg(CFG_STEP_RATIO, step_val);
			write_reg(CFG_REFILL_MARGIN, CFG_DATA_W'($urandom_range(0, 1024)));
			if (ph == 2)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
			if (ph == 7)
				quiet = 1'b1;
			wr_pct = (step_val > 24'h040000) ? 95 : $urandom_range(35, 65);
			// enough read ticks to back up the result queue during the long hold
			if (ph == 3)
				wr_pct = 50;
			n = $urandom_range(0, 40);
			repeat (n) queue_req(REQ_WRITE, rand_sample());
			repeat (220 - n) begin
				if ($urandom_range(1, 100) <= wr_pct)
					queue_req(REQ_WRITE, rand_sample());
				else
					queue_req(REQ_READ, SMP_W'($urandom));
			end
			if (ph == 3)
				hold_asked++;
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
